@@ hdl/mirrored_binary_shape_match_scorer_macros.svh @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIRRORED_BINARY_SHAPE_MATCH_SCORER_MACROS_SVH
`define MIRRORED_BINARY_SHAPE_MATCH_SCORER_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define MSMS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger that must be followed by a condition on the next clock edge.
`define MSMS_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ hdl/msms_pkg.sv @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer package
// Word types, widths, state and command encodings shared by the modules.
// ----------------------------------------------------------------------------
package msms_pkg;

    // Counter and arithmetic widths.
    localparam int CNT_W     = 21;
    localparam int CUT_W     = 16;
    localparam int PROD_W    = 2 * CNT_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CMP_SHIFT = 15;
    localparam int CMP_W     = SUM_W + CMP_SHIFT;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'h8000;
    localparam logic [7:0]       CHAN_WHITE   = 8'hFF;
    localparam logic [7:0]       CHAN_BLACK   = 8'h00;

    // One pixel word.
    typedef struct packed {
        logic [7:0] ref_red;
        logic [7:0] ref_green;
        logic [7:0] ref_blue;
        logic [7:0] cand_red;
        logic [7:0] cand_green;
        logic [7:0] cand_blue;
        logic [7:0] mirror_red;
        logic [7:0] mirror_green;
        logic [7:0] mirror_blue;
        logic       last_pixel;
    } pixel_t;

    // One score word.
    typedef struct packed {
        logic is_match;
        logic direct_match;
        logic mirrored_match;
        logic score_invalid;
    } score_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_CMP
    } state_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_WD_BD,
        MUL_DWH_BD,
        MUL_DBH_WD,
        MUL_MWH_BD,
        MUL_MBH_WD,
        MUL_PLO_CUT,
        MUL_PHI_CUT
    } mul_sel_t;

    // What to do with the registered product.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_P_LOAD,
        ACC_SD_LOAD,
        ACC_SD_ADD,
        ACC_SM_LOAD,
        ACC_SM_ADD,
        ACC_RHS_LOAD,
        ACC_RHS_ADD_HI
    } acc_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     count_en;
        logic     latch_den;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_result;
        logic     clear_counts;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pixel;
    } ctrl_stat_t;

endpackage

@@ hdl/mirrored_binary_shape_match_scorer.sv @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer
// Counts white/black pixels and matches, then scores direct and mirrored fit.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while pixel_ready is high. A pixel word with
// last_pixel set is counted and then scored in the denominator latch step, eight
// steps of one shared 21x21 multiplier with its accumulators, and the final
// compare, during which pixel_ready is low. The score word waits in an output
// register, so the next image may stream in while it is still pending. If that
// word has still not been taken when the next image reaches its final compare,
// the compare step waits for it and pixel_ready stays low until it is taken.
// cfg_data writes the Q0.16 cutoff and is always ready; it resets to 0.5.
// Counters saturate at 2^21-1.
module mirrored_binary_shape_match_scorer
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_ready,
    input  msms_pkg::pixel_t           pixel,
    output logic                       score_valid,
    input  logic                       score_ready,
    output msms_pkg::score_t           score,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [msms_pkg::CUT_W-1:0] cfg_data
);

    msms_pkg::ctrl_cmd_t  cmd;
    msms_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer.
    msms_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .score_valid (score_valid),
        .score_ready (score_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Counters and arithmetic.
    msms_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .score    (score)
    );

endmodule

@@ hdl/msms_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer controller
// Sequences pixel counting, the scoring steps and the score word handshake.
// ----------------------------------------------------------------------------
module msms_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    output logic                   score_valid,
    input  logic                   score_ready,
    input  msms_pkg::ctrl_stat_t   stat,
    output msms_pkg::ctrl_cmd_t    cmd
);

    msms_pkg::state_t state_reg;
    msms_pkg::state_t state_next;
    logic             score_valid_reg;
    logic             score_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= msms_pkg::ST_IDLE;
            score_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            score_valid_reg <= score_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.mul_sel      = msms_pkg::MUL_WD_BD;
        cmd.acc_op       = msms_pkg::ACC_NONE;
        pixel_ready      = 1'b0;
        score_valid_next = score_valid_reg && !score_ready;

        unique case (state_reg)
            msms_pkg::ST_IDLE:
            begin
                pixel_ready  = 1'b1;
                cmd.count_en = pixel_valid;
                if (pixel_valid && stat.last_pixel)
                begin
                    state_next = msms_pkg::ST_PREP;
                end
            end
            msms_pkg::ST_PREP:
            begin
                cmd.latch_den = 1'b1;
                state_next    = msms_pkg::ST_M1;
            end
            msms_pkg::ST_M1:
            begin
                cmd.mul_sel = msms_pkg::MUL_WD_BD;
                state_next  = msms_pkg::ST_M2;
            end
            msms_pkg::ST_M2:
            begin
                cmd.mul_sel = msms_pkg::MUL_DWH_BD;
                cmd.acc_op  = msms_pkg::ACC_P_LOAD;
                state_next  = msms_pkg::ST_M3;
            end
            msms_pkg::ST_M3:
            begin
                cmd.mul_sel = msms_pkg::MUL_DBH_WD;
                cmd.acc_op  = msms_pkg::ACC_SD_LOAD;
                state_next  = msms_pkg::ST_M4;
            end
            msms_pkg::ST_M4:
            begin
                cmd.mul_sel = msms_pkg::MUL_MWH_BD;
                cmd.acc_op  = msms_pkg::ACC_SD_ADD;
                state_next  = msms_pkg::ST_M5;
            end
            msms_pkg::ST_M5:
            begin
                cmd.mul_sel = msms_pkg::MUL_MBH_WD;
                cmd.acc_op  = msms_pkg::ACC_SM_LOAD;
                state_next  = msms_pkg::ST_M6;
            end
            msms_pkg::ST_M6:
            begin
                cmd.mul_sel = msms_pkg::MUL_PLO_CUT;
                cmd.acc_op  = msms_pkg::ACC_SM_ADD;
                state_next  = msms_pkg::ST_M7;
            end
            msms_pkg::ST_M7:
            begin
                cmd.mul_sel = msms_pkg::MUL_PHI_CUT;
                cmd.acc_op  = msms_pkg::ACC_RHS_LOAD;
                state_next  = msms_pkg::ST_M8;
            end
            msms_pkg::ST_M8:
            begin
                cmd.acc_op = msms_pkg::ACC_RHS_ADD_HI;
                state_next = msms_pkg::ST_CMP;
            end
            msms_pkg::ST_CMP:
            begin
                // Wait until the output register is free, then hand off.
                if (!score_valid_reg || score_ready)
                begin
                    cmd.load_result  = 1'b1;
                    cmd.clear_counts = 1'b1;
                    score_valid_next = 1'b1;
                    state_next       = msms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msms_pkg::ST_IDLE;
            end
        endcase
    end

    assign score_valid = score_valid_reg;

endmodule

@@ hdl/msms_dp.sv @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer datapath
// Pixel counters, shared multiplier, score accumulators and output register.
// ----------------------------------------------------------------------------
module msms_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  msms_pkg::pixel_t            pixel,
    input  logic                        cfg_we,
    input  logic [msms_pkg::CUT_W-1:0]  cfg_data,
    input  msms_pkg::ctrl_cmd_t         cmd,
    output msms_pkg::ctrl_stat_t        stat,
    output msms_pkg::score_t            score
);

    localparam int CW = msms_pkg::CNT_W;
    localparam int PW = msms_pkg::PROD_W;
    localparam int SW = msms_pkg::SUM_W;
    localparam int KW = msms_pkg::CMP_W;

    logic [msms_pkg::CUT_W-1:0] cutoff_reg;

    logic [CW-1:0] ref_white_reg;
    logic [CW-1:0] cand_white_reg;
    logic [CW-1:0] ref_black_reg;
    logic [CW-1:0] cand_black_reg;
    logic [CW-1:0] dwh_reg;
    logic [CW-1:0] dbh_reg;
    logic [CW-1:0] mwh_reg;
    logic [CW-1:0] mbh_reg;

    logic [CW-1:0] wd_reg;
    logic [CW-1:0] bd_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] p_reg;
    logic [SW-1:0] sd_reg;
    logic [SW-1:0] sm_reg;
    logic [KW-1:0] rhs_reg;
    msms_pkg::score_t score_reg;

    logic ref_white, ref_black, ref_all_white, ref_all_black;
    logic same_direct, same_mirror;
    logic [CW-1:0] mul_a, mul_b;
    logic [KW-1:0] lhs_direct, lhs_mirror;
    logic invalid, dm, mm;

    // Saturating increment.
    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c, input logic en);
        logic [CW-1:0] r;
        begin
            r = c;
            if (en && (c != {CW{1'b1}}))
            begin
                r = c + 1'b1;
            end
            return r;
        end
    endfunction

    // Per-pixel classification.
    assign ref_white     = (pixel.ref_red == msms_pkg::CHAN_WHITE);
    assign ref_black     = (pixel.ref_red == msms_pkg::CHAN_BLACK);
    assign ref_all_white = ref_white && (pixel.ref_green == msms_pkg::CHAN_WHITE)
                           && (pixel.ref_blue == msms_pkg::CHAN_WHITE);
    assign ref_all_black = ref_black && (pixel.ref_green == msms_pkg::CHAN_BLACK)
                           && (pixel.ref_blue == msms_pkg::CHAN_BLACK);
    assign same_direct   = (pixel.ref_red == pixel.cand_red)
                           && (pixel.ref_green == pixel.cand_green)
                           && (pixel.ref_blue == pixel.cand_blue);
    assign same_mirror   = (pixel.ref_red == pixel.mirror_red)
                           && (pixel.ref_green == pixel.mirror_green)
                           && (pixel.ref_blue == pixel.mirror_blue);

    assign stat.last_pixel = pixel.last_pixel;

    // Cutoff register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= msms_pkg::CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            cutoff_reg <= cfg_data;
        end
    end

    // Pixel counters; they clear once the score word is handed off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_white_reg  <= '0;
            cand_white_reg <= '0;
            ref_black_reg  <= '0;
            cand_black_reg <= '0;
            dwh_reg        <= '0;
            dbh_reg        <= '0;
            mwh_reg        <= '0;
            mbh_reg        <= '0;
        end
        else if (cmd.clear_counts)
        begin
            ref_white_reg  <= '0;
            cand_white_reg <= '0;
            ref_black_reg  <= '0;
            cand_black_reg <= '0;
            dwh_reg        <= '0;
            dbh_reg        <= '0;
            mwh_reg        <= '0;
            mbh_reg        <= '0;
        end
        else if (cmd.count_en)
        begin
            ref_white_reg  <= sat_inc(ref_white_reg, ref_white);
            cand_white_reg <= sat_inc(cand_white_reg,
                                      pixel.cand_red == msms_pkg::CHAN_WHITE);
            ref_black_reg  <= sat_inc(ref_black_reg, ref_black);
            cand_black_reg <= sat_inc(cand_black_reg,
                                      pixel.cand_red == msms_pkg::CHAN_BLACK);
            dwh_reg        <= sat_inc(dwh_reg, same_direct && ref_all_white);
            dbh_reg        <= sat_inc(dbh_reg, same_direct && ref_all_black);
            mwh_reg        <= sat_inc(mwh_reg, same_mirror && ref_all_white);
            mbh_reg        <= sat_inc(mbh_reg, same_mirror && ref_all_black);
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_sel)
            msms_pkg::MUL_WD_BD:   begin mul_a = wd_reg;  mul_b = bd_reg; end
            msms_pkg::MUL_DWH_BD:  begin mul_a = dwh_reg; mul_b = bd_reg; end
            msms_pkg::MUL_DBH_WD:  begin mul_a = dbh_reg; mul_b = wd_reg; end
            msms_pkg::MUL_MWH_BD:  begin mul_a = mwh_reg; mul_b = bd_reg; end
            msms_pkg::MUL_MBH_WD:  begin mul_a = mbh_reg; mul_b = wd_reg; end
            msms_pkg::MUL_PLO_CUT:
            begin
                mul_a = p_reg[CW-1:0];
                mul_b = CW'(cutoff_reg);
            end
            msms_pkg::MUL_PHI_CUT:
            begin
                mul_a = p_reg[PW-1:CW];
                mul_b = CW'(cutoff_reg);
            end
            default:               begin mul_a = wd_reg;  mul_b = bd_reg; end
        endcase
    end

    // Denominators, registered product and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_den)
        begin
            wd_reg <= (cand_white_reg > ref_white_reg) ? cand_white_reg : ref_white_reg;
            bd_reg <= (cand_black_reg > ref_black_reg) ? cand_black_reg : ref_black_reg;
        end
        prod_reg <= mul_a * mul_b;
        unique case (cmd.acc_op)
            msms_pkg::ACC_NONE:       ;
            msms_pkg::ACC_P_LOAD:     p_reg   <= prod_reg;
            msms_pkg::ACC_SD_LOAD:    sd_reg  <= SW'(prod_reg);
            msms_pkg::ACC_SD_ADD:     sd_reg  <= sd_reg + SW'(prod_reg);
            msms_pkg::ACC_SM_LOAD:    sm_reg  <= SW'(prod_reg);
            msms_pkg::ACC_SM_ADD:     sm_reg  <= sm_reg + SW'(prod_reg);
            msms_pkg::ACC_RHS_LOAD:   rhs_reg <= KW'(prod_reg);
            msms_pkg::ACC_RHS_ADD_HI: rhs_reg <= rhs_reg + (KW'(prod_reg) << CW);
            default:                  ;
        endcase
    end

    // Final compare: sum * 2^15 against product * cutoff.
    assign lhs_direct = {sd_reg, {msms_pkg::CMP_SHIFT{1'b0}}};
    assign lhs_mirror = {sm_reg, {msms_pkg::CMP_SHIFT{1'b0}}};
    assign invalid    = (wd_reg == '0) || (bd_reg == '0);
    assign dm         = !invalid && (lhs_direct > rhs_reg);
    assign mm         = !invalid && (lhs_mirror > rhs_reg);

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            score_reg.is_match       <= dm || mm;
            score_reg.direct_match   <= dm;
            score_reg.mirrored_match <= mm;
            score_reg.score_invalid  <= invalid;
        end
    end

    assign score = score_reg;

endmodule

@@ hdl/msms_checker.sv @@
// ----------------------------------------------------------------------------
// Mirrored binary shape match scorer port checker
// Watches the top-level ports for handshake and score word consistency.
// ----------------------------------------------------------------------------
`include "mirrored_binary_shape_match_scorer_macros.svh"

module msms_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input msms_pkg::pixel_t pixel,
    input logic             score_valid,
    input logic             score_ready,
    input msms_pkg::score_t score
);

    // A pending score word is held until it is taken.
    `MSMS_ASSERT_NEXT(a_score_hold, clk, rst_n, score_valid && !score_ready, score_valid, "score word dropped")

    // The combined flag is the OR of the two case flags.
    `MSMS_ASSERT(a_match_or, clk, rst_n, !score_valid || (score.is_match == (score.direct_match || score.mirrored_match)), "is_match inconsistent")

    // An invalid score never reports a match.
    `MSMS_ASSERT(a_invalid_nomatch, clk, rst_n, !score_valid || !score.score_invalid || (!score.direct_match && !score.mirrored_match), "match on invalid score")

    // Scoring blocks new pixels right after the last one.
    `MSMS_ASSERT_NEXT(a_last_stalls, clk, rst_n, pixel_valid && pixel_ready && pixel.last_pixel, !pixel_ready, "pixel taken during scoring")

endmodule

bind mirrored_binary_shape_match_scorer msms_checker u_msms_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .score_valid (score_valid),
    .score_ready (score_ready),
    .score       (score)
);
